/* src/rwmv_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register indexes and constants for the weighted mean and variance block.
package rwmv_pkg;

	// Default frame size limits handed to the top level parameters
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	localparam cfg_index_t REG_FRAME_WIDTH   = 3'd0;
	localparam cfg_index_t REG_FRAME_HEIGHT  = 3'd1;
	localparam cfg_index_t REG_MARGIN_LEFT   = 3'd2;
	localparam cfg_index_t REG_MARGIN_RIGHT  = 3'd3;
	localparam cfg_index_t REG_MARGIN_TOP    = 3'd4;
	localparam cfg_index_t REG_MARGIN_BOTTOM = 3'd5;

	// Register reset values
	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

	// Field and accumulator widths
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 9;
	localparam int VAR_W    = 31;
	localparam int ACC_W_W  = 31;
	localparam int ACC_T_W  = 46;
	localparam int ACC_Q_W  = 61;

	// Mean reported for an empty region (1.0 in Q8.8)
	localparam logic signed [SAMPLE_W-1:0] MEAN_ONE = 16'sd256;

	// Restoring divider: one quotient bit per step over the widest dividend
	localparam int DIV_STEPS = ACC_Q_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_DIV_T,
		ST_MEAN,
		ST_DIV_Q,
		ST_SQUARE,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take_in;   // input channel open
		logic div_step;  // one divider iteration
		logic div_next;  // keep mean, load square sum into divider
		logic sq_calc;   // square the mean
		logic out_load;  // load the result word
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic accept;    // pixel taken this cycle
		logic frame_end; // current pixel is the last of the frame
		logic snap;      // frame totals taken, divider loaded
		logic w_zero;    // region weight sum was zero
		logic out_free;  // result register can take a word
	} status_t;

endpackage

/* src/rwmv_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for pixel accumulation, the frame-end divisions and result hand-off.
module rwmv_ctrl
	import rwmv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_ACCUM: begin
				cmd.take_in = 1'b1;
				if (status.accept && status.frame_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the last pixel to reach the accumulators
				cnt_d = '0;
				if (status.snap) begin
					state_d = ST_DIV_T;
				end
			end
			ST_DIV_T: begin
				if (status.w_zero) begin
					state_d = ST_OUT;
				end else begin
					cmd.div_step = 1'b1;
					if (cnt_q == DIV_LAST) begin
						cnt_d   = '0;
						state_d = ST_MEAN;
					end else begin
						cnt_d = cnt_q + DIV_CNT_W'(1);
					end
				end
			end
			ST_MEAN: begin
				cmd.div_next = 1'b1;
				state_d      = ST_DIV_Q;
			end
			ST_DIV_Q: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = ST_SQUARE;
				end else begin
					cnt_d = cnt_q + DIV_CNT_W'(1);
				end
			end
			ST_SQUARE: begin
				cmd.sq_calc = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

endmodule

/* src/rwmv_datapath.sv */
`timescale 1ns / 1ps
// Counters, product pipeline, accumulators, shared divider and result register.
module rwmv_datapath
	import rwmv_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  cfg_index_t                 cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [WEIGHT_W-1:0]        weight,
	input  logic                       out_stall,
	input  cmd_t                       cmd,
	output status_t                    status,
	output logic                       out_valid,
	output logic signed [SAMPLE_W-1:0] mean,
	output logic [VAR_W-1:0]           variance,
	output logic                       zero_weight
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam logic [11:0] MAX_W12 = 12'(MAX_WIDTH);
	localparam logic [11:0] MAX_H12 = 12'(MAX_HEIGHT);

	// Configuration registers
	logic [11:0] frame_width_q, frame_height_q;
	logic [10:0] margin_left_q, margin_right_q, margin_top_q, margin_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FRAME_WIDTH_RST;
			frame_height_q  <= FRAME_HEIGHT_RST;
			margin_left_q   <= '0;
			margin_right_q  <= '0;
			margin_top_q    <= '0;
			margin_bottom_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:   frame_width_q   <= cfg_data;
				REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data;
				REG_MARGIN_LEFT:   margin_left_q   <= cfg_data[10:0];
				REG_MARGIN_RIGHT:  margin_right_q  <= cfg_data[10:0];
				REG_MARGIN_TOP:    margin_top_q    <= cfg_data[10:0];
				REG_MARGIN_BOTTOM: margin_bottom_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Effective frame size: zero acts as one, clamp to the limits
	logic [11:0] w_eff, h_eff;
	assign w_eff = (frame_width_q == '0) ? 12'd1 :
	               (frame_width_q > MAX_W12) ? MAX_W12 : frame_width_q;
	assign h_eff = (frame_height_q == '0) ? 12'd1 :
	               (frame_height_q > MAX_H12) ? MAX_H12 : frame_height_q;

	// Raster position and region test
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [12:0]   col_x, row_x;
	logic          in_cols, in_rows, in_region, row_end, frame_end, accept;

	assign col_x     = 13'(col_q);
	assign row_x     = 13'(row_q);
	assign in_cols   = (col_x >= 13'(margin_left_q)) &&
	                   (col_x + 13'(margin_right_q) < 13'(w_eff));
	assign in_rows   = (row_x >= 13'(margin_top_q)) &&
	                   (row_x + 13'(margin_bottom_q) < 13'(h_eff));
	assign in_region = in_cols && in_rows;
	assign row_end   = (col_x + 13'd1) >= 13'(w_eff);
	assign frame_end = row_end && ((row_x + 13'd1) >= 13'(h_eff));
	assign accept    = in_valid && cmd.take_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!row_end) begin
				col_q <= col_q + CW'(1);
			end else begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + RW'(1);
			end
		end
	end

	// Stage 1: sample squared and sample times weight
	logic                valid_s1, region_s1, fend_s1;
	logic [30:0]         sq_s1;
	logic signed [25:0]  sw_s1;
	logic [WEIGHT_W-1:0] wt_s1;
	logic signed [31:0]  sq_full;
	logic signed [25:0]  sw_full;

	assign sq_full = 32'(sample) * 32'(sample);
	assign sw_full = 26'(sample) * 26'(signed'({1'b0, weight}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		region_s1 <= in_region;
		fend_s1   <= frame_end;
		sq_s1     <= sq_full[30:0];
		sw_s1     <= sw_full;
		wt_s1     <= weight;
	end

	// Stage 2: square times weight
	logic                valid_s2, region_s2, fend_s2;
	logic [39:0]         sqw_s2;
	logic signed [25:0]  sw_s2;
	logic [WEIGHT_W-1:0] wt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		region_s2 <= region_s1;
		fend_s2   <= fend_s1;
		sqw_s2    <= 40'(sq_s1) * 40'(wt_s1);
		sw_s2     <= sw_s1;
		wt_s2     <= wt_s1;
	end

	// Accumulators; totals including the current pixel
	logic [ACC_W_W-1:0]        acc_w_q, tot_w;
	logic signed [ACC_T_W-1:0] acc_t_q, tot_t;
	logic [ACC_Q_W-1:0]        acc_q_q, tot_q;
	logic                      add_en, snap;

	assign add_en = valid_s2 && region_s2;
	assign snap   = valid_s2 && fend_s2;
	assign tot_w  = add_en ? acc_w_q + ACC_W_W'(wt_s2) : acc_w_q;
	assign tot_t  = add_en ? acc_t_q + ACC_T_W'(sw_s2) : acc_t_q;
	assign tot_q  = add_en ? acc_q_q + ACC_Q_W'(sqw_s2) : acc_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_w_q <= '0;
			acc_t_q <= '0;
			acc_q_q <= '0;
		end else if (snap) begin
			acc_w_q <= '0;
			acc_t_q <= '0;
			acc_q_q <= '0;
		end else begin
			acc_w_q <= tot_w;
			acc_t_q <= tot_t;
			acc_q_q <= tot_q;
		end
	end

	// Frame totals and shared restoring divider (dividend reg collects the quotient)
	logic [ACC_W_W-1:0]      w_snap_q;
	logic [ACC_Q_W-1:0]      q_snap_q;
	logic                    t_neg_q, zero_q;
	logic [ACC_Q_W-1:0]      div_dvd_q;
	logic [ACC_W_W:0]        div_rem_q;
	logic [ACC_T_W-1:0]      t_mag;
	logic [ACC_W_W:0]        rem_sh;
	logic [ACC_W_W+1:0]      rem_diff;
	logic signed [SAMPLE_W-1:0] mean_q, mean_clamp;
	logic [31:0]             msq_q;
	logic signed [31:0]      msq_full;

	assign t_mag    = tot_t[ACC_T_W-1] ? ACC_T_W'(-tot_t) : ACC_T_W'(tot_t);
	assign rem_sh   = {div_rem_q[ACC_W_W-1:0], div_dvd_q[ACC_Q_W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, w_snap_q};

	// Truncated quotient magnitude back to a signed, saturated mean
	always_comb begin
		if (t_neg_q) begin
			mean_clamp = (div_dvd_q > ACC_Q_W'(32768)) ? 16'sh8000 :
			             SAMPLE_W'(-div_dvd_q);
		end else begin
			mean_clamp = (div_dvd_q > ACC_Q_W'(32767)) ? 16'sh7FFF :
			             SAMPLE_W'(div_dvd_q);
		end
	end

	assign msq_full = 32'(mean_q) * 32'(mean_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b0;
		end else if (snap) begin
			zero_q <= (tot_w == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (snap) begin
			w_snap_q  <= tot_w;
			q_snap_q  <= tot_q;
			t_neg_q   <= tot_t[ACC_T_W-1];
			div_dvd_q <= ACC_Q_W'(t_mag);
			div_rem_q <= '0;
		end else if (cmd.div_next) begin
			mean_q    <= mean_clamp;
			div_dvd_q <= q_snap_q;
			div_rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_diff[ACC_W_W+1]) begin
				div_rem_q <= rem_sh;
				div_dvd_q <= {div_dvd_q[ACC_Q_W-2:0], 1'b0};
			end else begin
				div_rem_q <= rem_diff[ACC_W_W:0];
				div_dvd_q <= {div_dvd_q[ACC_Q_W-2:0], 1'b1};
			end
		end
		if (cmd.sq_calc) begin
			msq_q <= 32'(msq_full);
		end
	end

	// Variance: mean of squares less squared mean, floored at zero
	logic [ACC_Q_W-1:0] var_diff;
	logic [VAR_W-1:0]   var_val;

	assign var_diff = div_dvd_q - ACC_Q_W'(msq_q);
	assign var_val  = (div_dvd_q > ACC_Q_W'(msq_q)) ? var_diff[VAR_W-1:0] : '0;

	// Result register
	logic out_valid_q, out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean        <= zero_q ? MEAN_ONE : mean_q;
			variance    <= zero_q ? '0 : var_val;
			zero_weight <= zero_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.accept    = accept;
	assign status.frame_end = frame_end;
	assign status.snap      = snap;
	assign status.w_zero    = zero_q;
	assign status.out_free  = out_free;

	// Nothing follows the frame-end pixel through the pipeline
	a_snap_drained: assert property (@(posedge clk) disable iff (!arst_n)
		snap |-> !valid_s1)
		else $error("pixel behind frame end in pipeline");

	// Accumulators start the next frame from zero
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		snap |=> (acc_w_q == '0) && (acc_t_q == '0) && (acc_q_q == '0))
		else $error("accumulators not cleared at frame end");

	// A waiting result word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result word overwritten while stalled");

endmodule

/* src/roi_weighted_mean_variance.sv */
`timescale 1ns / 1ps
// Top level of the region-of-interest weighted mean and variance block.
// Pixels are taken one per cycle in raster order while a frame streams in; inside the region
// left by the four margins each pixel adds its weight, sample times weight and squared sample
// times weight to three accumulators through a two-stage product pipeline. After the last
// pixel of the frame the input is held off through these steps: draining the pipeline, 61
// steps of one shared bit-per-cycle restoring divider for the mean, keeping the mean and
// reloading the divider, 61 steps for the mean of squares, then squaring the mean and loading
// the result. An empty region skips the divisions and holds the input off until its result is
// loaded. The result word sits in an output register, so the next frame can start
// streaming while it waits to be taken; the result load of the following frame waits, with the
// input still held off, until the earlier word has gone. Configuration is written through a
// plain write port with no read-back.
module roi_weighted_mean_variance
	import rwmv_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  cfg_index_t                 cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [WEIGHT_W-1:0]        weight,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] mean,
	output logic [VAR_W-1:0]           variance,
	output logic                       zero_weight
);

	cmd_t    cmd;
	status_t status;

	rwmv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	rwmv_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.sample      (sample),
		.weight      (weight),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.mean        (mean),
		.variance    (variance),
		.zero_weight (zero_weight)
	);

	// input word taken only while accumulating
	assign in_stall = !cmd.take_in;

endmodule
